@@ hdl/ppp_pkg.sv @@
// shared constants, types and helpers of the polyline point projection unit
package ppp_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int DIV_STEPS    = 31;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] start_arc;
        logic signed [31:0] end_arc;
    } t_seg;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT0, S_INIT1, S_SEG, S_L0, S_L1, S_L2, S_L3, S_L4,
        S_DIV_GO, S_DIV, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_NEXT, S_DONE
    } t_state;

    // difference of two 32-bit values, sign extended to 34 bits
    function automatic logic signed [33:0] diff34(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        diff34 = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    endfunction

    // symmetric saturation to +-(2^31-1)
    function automatic logic signed [31:0] sat31(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            sat31 = 32'sd2147483647;
        end else if (v < -34'sd2147483647) begin
            sat31 = -32'sd2147483647;
        end else begin
            sat31 = v[31:0];
        end
    endfunction

endpackage

@@ hdl/ppp_if.sv @@
// valid/ready channels for query items and results
interface ppp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] start_arc;
    logic signed [31:0] end_arc;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] min_arc;
    modport source (output valid, action, start_x, start_y, end_x, end_y, start_arc,
                    end_arc, point_x, point_y, min_arc, input ready);
    modport sink (input valid, action, start_x, start_y, end_x, end_y, start_arc,
                  end_arc, point_x, point_y, min_arc, output ready);
endinterface

interface ppp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] arc_position;
    logic               matched;
    logic               empty_error;
    modport source (output valid, arc_position, matched, empty_error, input ready);
    modport sink (input valid, arc_position, matched, empty_error, output ready);
endinterface

@@ hdl/ppp_cell.sv @@
// one segment slot of the rotating segment chain
module ppp_cell (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic         i_shift,
    input  ppp_pkg::t_seg i_load_seg,
    input  ppp_pkg::t_seg i_next_seg,
    output ppp_pkg::t_seg o_seg
);
    import ppp_pkg::*;

    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg <= i_load_seg;
        end else if (i_shift) begin
            r_seg <= i_next_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

@@ hdl/ppp_div.sv @@
// restoring divider giving floor(num * 2^30 / den) for num <= den
module ppp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quo
);
    import ppp_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_rem;
    logic [30:0]          r_quo;
    logic [63:0]          w_rs;
    logic                 w_ge;

    // first step compares without the shift
    assign w_rs = (r_cnt == '0) ? r_rem : {r_rem[62:0], 1'b0};
    assign w_ge = (w_rs >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rs - i_den) : w_rs;
            r_quo <= {r_quo[29:0], w_ge};
        end
    end

    assign o_done = r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_quo  = {r_quo[29:0], w_ge};

endmodule

@@ hdl/polyline_point_projection_unit.sv @@
// top level: segment chain, projection sequencer and result register
// append and clear are taken in the idle state and can follow back to back; an empty-table
// query shows its result the cycle after the transfer; otherwise the sequencer first takes
// the squared distance to segment 0's start, then visits every table slot (MAX_SEGMENTS):
// an eligible segment passes the length, dot product, divider and distance steps, a closer
// one also the arc step; no new item is taken until the result has been accepted
// synchronous active-low reset clears the segment count, sequencer and output valid
module polyline_point_projection_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ppp_in_if.sink    i_in,
    ppp_out_if.source o_out
);
    import ppp_pkg::*;

    // sequencer state
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;

    // query operands and working registers
    logic signed [31:0] r_px, n_px, r_py, n_py, r_min, n_min;
    logic signed [31:0] r_dx, n_dx, r_dy, n_dy, r_qx, n_qx, r_qy, n_qy;
    logic signed [31:0] r_ex, n_ex, r_ey, n_ey;
    logic signed [63:0] r_acc, n_acc, r_dot, n_dot;
    logic [63:0]        r_len2, n_len2, r_best, n_best;
    logic [30:0]        r_t, n_t;

    // result register
    logic signed [31:0] r_arc, n_arc;
    logic               r_matched, n_matched, r_empty, n_empty;

    // chain of segment cells; cell 0 is the head seen by the sequencer
    t_seg w_cell [MAX_SEGMENTS];
    t_seg w_new_seg, w_head;
    logic w_shift, w_append;

    // shared multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [33:0] w_cand;

    // divider
    logic        w_div_start, w_div_done;
    logic [30:0] w_div_quo;

    assign w_new_seg = '{start_x: i_in.start_x, start_y: i_in.start_y,
                         end_x: i_in.end_x, end_y: i_in.end_y,
                         start_arc: i_in.start_arc, end_arc: i_in.end_arc};
    assign w_head    = w_cell[0];
    assign w_append  = (r_state == S_IDLE) && i_in.valid && (i_in.action == ACT_APPEND)
                       && (r_count < CNT_W'(MAX_SEGMENTS));
    assign w_shift   = (r_state == S_NEXT);

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        ppp_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_append && (r_count == CNT_W'(g))),
            .i_shift    (w_shift),
            .i_load_seg (w_new_seg),
            .i_next_seg (w_cell[(g + 1) % MAX_SEGMENTS]),
            .o_seg      (w_cell[g])
        );
    end

    ppp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dot),
        .i_den   (r_len2),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_div_start = (r_state == S_DIV_GO);

    // operand select for the one multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_INIT0: begin
                w_ma = sat31(diff34(w_head.start_x, r_px));
                w_mb = w_ma;
            end
            S_INIT1: begin
                w_ma = sat31(diff34(w_head.start_y, r_py));
                w_mb = w_ma;
            end
            S_L0: begin w_ma = r_dx; w_mb = r_dx; end
            S_L1: begin w_ma = r_dy; w_mb = r_dy; end
            S_L2: begin w_ma = r_qx; w_mb = r_dx; end
            S_L3: begin w_ma = r_qy; w_mb = r_dy; end
            S_P0: begin w_ma = signed'({1'b0, r_t}); w_mb = r_dx; end
            S_P1: begin w_ma = signed'({1'b0, r_t}); w_mb = r_dy; end
            S_P2: begin w_ma = r_ex; w_mb = r_ex; end
            S_P3: begin w_ma = r_ey; w_mb = r_ey; end
            S_P5: begin
                w_ma = signed'({1'b0, r_t});
                w_mb = sat31(diff34(w_head.end_arc, w_head.start_arc));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);
    // interpolated arc, offset floored by the arithmetic shift
    assign w_cand = {{2{w_head.start_arc[31]}}, w_head.start_arc} + 34'(w_prod >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px      <= n_px;
        r_py      <= n_py;
        r_min     <= n_min;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_ex      <= n_ex;
        r_ey      <= n_ey;
        r_acc     <= n_acc;
        r_dot     <= n_dot;
        r_len2    <= n_len2;
        r_best    <= n_best;
        r_t       <= n_t;
        r_arc     <= n_arc;
        r_matched <= n_matched;
        r_empty   <= n_empty;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_px      = r_px;
        n_py      = r_py;
        n_min     = r_min;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_qx      = r_qx;
        n_qy      = r_qy;
        n_ex      = r_ex;
        n_ey      = r_ey;
        n_acc     = r_acc;
        n_dot     = r_dot;
        n_len2    = r_len2;
        n_best    = r_best;
        n_t       = r_t;
        n_arc     = r_arc;
        n_matched = r_matched;
        n_empty   = r_empty;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    priority case (i_in.action)
                        ACT_CLEAR: n_count = '0;
                        ACT_APPEND: begin
                            if (w_append) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_px      = i_in.point_x;
                            n_py      = i_in.point_y;
                            n_min     = i_in.min_arc;
                            n_arc     = i_in.min_arc;
                            n_matched = 1'b0;
                            n_idx     = '0;
                            if (r_count == '0) begin
                                n_empty = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_empty = 1'b0;
                                n_state = S_INIT0;
                            end
                        end
                        default: n_state = S_IDLE;  // unused code, no effect
                    endcase
                end
            end
            // initial best: squared distance to the start of segment 0
            S_INIT0: begin
                n_acc   = w_prod;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                n_best  = 64'(r_acc) + 64'(w_prod);
                n_state = S_SEG;
            end
            S_SEG: begin
                if (r_idx == CNT_W'(MAX_SEGMENTS)) begin
                    n_state = S_DONE;
                end else if ((r_idx >= r_count) || (w_head.start_arc < r_min)) begin
                    n_state = S_NEXT;
                end else begin
                    n_dx    = sat31(diff34(w_head.end_x, w_head.start_x));
                    n_dy    = sat31(diff34(w_head.end_y, w_head.start_y));
                    n_qx    = sat31(diff34(r_px, w_head.start_x));
                    n_qy    = sat31(diff34(r_py, w_head.start_y));
                    n_state = S_L0;
                end
            end
            S_L0: begin
                n_acc   = w_prod;
                n_state = S_L1;
            end
            S_L1: begin
                n_len2  = 64'(r_acc) + 64'(w_prod);
                n_state = S_L2;
            end
            S_L2: begin
                n_acc   = w_prod;
                n_state = S_L3;
            end
            S_L3: begin
                n_dot   = r_acc + w_prod;
                n_state = S_L4;
            end
            // zero-length segment or projection outside the segment
            S_L4: begin
                if ((r_len2 == '0) || r_dot[63] || (64'(r_dot) > r_len2)) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_t     = w_div_quo;
                    n_state = S_P0;
                end
            end
            S_P0: begin
                n_ex    = sat31({{2{r_qx[31]}}, r_qx} - 34'(w_prod >>> 30));
                n_state = S_P1;
            end
            S_P1: begin
                n_ey    = sat31({{2{r_qy[31]}}, r_qy} - 34'(w_prod >>> 30));
                n_state = S_P2;
            end
            S_P2: begin
                n_acc   = w_prod;
                n_state = S_P3;
            end
            S_P3: begin
                n_len2  = 64'(r_acc) + 64'(w_prod);  // reused to hold the distance
                n_state = S_P4;
            end
            S_P4: begin
                if (r_len2 < r_best) begin
                    n_best  = r_len2;
                    n_state = S_P5;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_P5: begin
                if (w_cand > 34'sd2147483647) begin
                    n_arc = 32'sd2147483647;
                end else if (w_cand < -34'sd2147483648) begin
                    n_arc = -32'sd2147483648;
                end else begin
                    n_arc = w_cand[31:0];
                end
                n_matched = 1'b1;
                n_state   = S_NEXT;
            end
            // rotate the chain by one slot
            S_NEXT: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_SEG;
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_DONE);
    assign o_out.arc_position = r_arc;
    assign o_out.matched      = r_matched;
    assign o_out.empty_error  = r_empty;

endmodule
